@@ rtl/vtg_pkg.sv @@
// Package for the video timing generator: timing constants, register
// indexes, the result and geometry types and the mode decode function.
// No dependencies.
package vtg_pkg;

	localparam logic [11:0] H_STEP    = 12'd12;
	localparam logic [11:0] H_SYNC_ON = 12'd1800;
	localparam logic [11:0] H_TOTAL   = 12'd2172;

	localparam int unsigned CFG_ADDR_W = 5;

	// Register indexes on the configuration port (byte address is four times this).
	localparam logic [2:0] REG_HRES     = 3'd0;
	localparam logic [2:0] REG_VRES     = 3'd1;
	localparam logic [2:0] REG_ILACE    = 3'd2;
	localparam logic [2:0] REG_STANDARD = 3'd3;
	localparam logic [2:0] REG_LINES    = 3'd4;
	localparam logic [2:0] REG_VSTART   = 3'd5;
	localparam logic [2:0] REG_VEND     = 3'd6;

	localparam logic [8:0] LINES_RESET  = 9'd263;
	localparam logic [8:0] VSTART_RESET = 9'd16;
	localparam logic [8:0] VEND_RESET   = 9'd256;

	typedef struct packed {
		logic [3:0] dot_divider;
		logic [9:0] display_width;
		logic [9:0] display_height;
		logic       display_interlaced;
	} vtg_geom_t;

	localparam vtg_geom_t GEOM_RESET = '{
		dot_divider:        4'd10,
		display_width:      10'd256,
		display_height:     10'd240,
		display_interlaced: 1'b0
	};

	typedef struct packed {
		logic       hsync_level;
		logic       vsync_level;
		logic       vblank_raise;
		logic       vblank_lower;
		logic       frame_ready;
		logic       field_odd;
		logic [3:0] dot_divider;
		logic [9:0] display_width;
		logic [9:0] display_height;
		logic       display_interlaced;
		logic [11:0] h_position;
		logic [8:0] v_position;
	} vtg_result_t;

	// Decodes the mode registers into the geometry latched at a frame wrap.
	function automatic vtg_geom_t vtg_geometry(input logic [2:0] hres, input logic vres,
			input logic ilace, input logic standard);
		vtg_geom_t g;
		case (hres)
			3'd0: begin
				g.dot_divider   = 4'd10;
				g.display_width = 10'd256;
			end
			3'd1: begin
				g.dot_divider   = 4'd8;
				g.display_width = 10'd320;
			end
			3'd2: begin
				g.dot_divider   = 4'd5;
				g.display_width = 10'd512;
			end
			3'd3: begin
				g.dot_divider   = 4'd4;
				g.display_width = 10'd640;
			end
			default: begin
				g.dot_divider   = 4'd7;
				g.display_width = 10'd368;
			end
		endcase
		if (vres && ilace) begin
			g.display_height     = standard ? 10'd512 : 10'd480;
			g.display_interlaced = 1'b1;
		end else begin
			g.display_height     = standard ? 10'd256 : 10'd240;
			g.display_interlaced = 1'b0;
		end
		return g;
	endfunction

endpackage

@@ rtl/vtg_stream_if.sv @@
// Valid/ready channel interfaces for the video timing generator:
// the tick input channel and the timing result channel. Depends on vtg_pkg.
interface vtg_tick_if;
	logic valid;
	logic ready;
	logic tick;

	modport source (output valid, output tick, input ready);
	modport sink (input valid, input tick, output ready);
endinterface

interface vtg_timing_if
	import vtg_pkg::*;
;
	logic        valid;
	logic        ready;
	vtg_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/video_timing_generator_unit.sv @@
// Video timing generator top level: horizontal and line counters, sync levels,
// vblank pulses and latched display geometry. Depends on vtg_pkg and vtg_stream_if.
//
// Channel    Direction  Payload                          Transaction
// tick_ch    in         tick                             valid & ready
// timing_ch  out        vtg_result_t (sync, geometry)    valid & ready
// APB        in/out     seven mode and line registers    psel & penable & pready
//
// One tick transaction per cycle when not stalled; its result appears in the result
// register on the next cycle. The limit is the single counter update between the
// state registers and the result register. The tick channel is ready whenever the
// result register is empty or being taken in the same cycle. Reset clears the
// counters and restores the register and geometry defaults; no clearing pass.
module video_timing_generator_unit
	import vtg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	vtg_tick_if.sink              tick_ch,
	vtg_timing_if.source          timing_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [2:0] hres_q;
	logic       vres_q;
	logic       ilace_q;
	logic       standard_q;
	logic [8:0] lines_q;
	logic [8:0] vstart_q;
	logic [8:0] vend_q;

	logic [11:0] h_count_q;
	logic [8:0]  v_count_q;
	logic        field_q;
	logic        hsync_q;
	logic        vsync_q;
	vtg_geom_t   geom_q;

	logic        res_valid_q;
	vtg_result_t res_q;

	logic [2:0]  reg_idx;
	logic        cfg_write;
	logic        accept;

	logic [11:0] h_sum;
	logic [8:0]  v_inc;
	logic [11:0] h_next;
	logic [8:0]  v_next;
	logic        field_next;
	logic        hsync_next;
	logic        vsync_next;
	logic        raise;
	logic        lower;
	vtg_geom_t   geom_next;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[CFG_ADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_idx)
			REG_HRES:     prdata = {29'd0, hres_q};
			REG_VRES:     prdata = {31'd0, vres_q};
			REG_ILACE:    prdata = {31'd0, ilace_q};
			REG_STANDARD: prdata = {31'd0, standard_q};
			REG_LINES:    prdata = {23'd0, lines_q};
			REG_VSTART:   prdata = {23'd0, vstart_q};
			REG_VEND:     prdata = {23'd0, vend_q};
			default:      prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hres_q     <= 3'd0;
			vres_q     <= 1'b0;
			ilace_q    <= 1'b0;
			standard_q <= 1'b0;
			lines_q    <= LINES_RESET;
			vstart_q   <= VSTART_RESET;
			vend_q     <= VEND_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_HRES:     hres_q     <= pwdata[2:0];
				REG_VRES:     vres_q     <= pwdata[0];
				REG_ILACE:    ilace_q    <= pwdata[0];
				REG_STANDARD: standard_q <= pwdata[0];
				REG_LINES:    lines_q    <= pwdata[8:0];
				REG_VSTART:   vstart_q   <= pwdata[8:0];
				REG_VEND:     vend_q     <= pwdata[8:0];
				default:      ;
			endcase
		end
	end

	assign tick_ch.ready = !res_valid_q || timing_ch.ready;
	assign accept        = tick_ch.valid && tick_ch.ready;

	always_comb begin
		h_sum      = h_count_q + H_STEP;
		v_inc      = v_count_q + 9'd1;
		h_next     = h_count_q;
		v_next     = v_count_q;
		field_next = field_q;
		hsync_next = hsync_q;
		vsync_next = vsync_q;
		geom_next  = geom_q;
		raise      = 1'b0;
		lower      = 1'b0;
		if (tick_ch.tick) begin
			h_next = h_sum;
			if (h_sum == H_SYNC_ON) begin
				hsync_next = 1'b1;
			end
			if (h_sum == H_TOTAL) begin
				h_next     = 12'd0;
				hsync_next = 1'b0;
				v_next     = v_inc;
				// A zero total matches when the nine-bit counter wraps past 511.
				if (v_inc == lines_q) begin
					v_next     = 9'd0;
					field_next = !field_q;
					geom_next  = vtg_geometry(hres_q, vres_q, ilace_q, standard_q);
				end
				if (v_next == vstart_q) begin
					vsync_next = 1'b0;
					lower      = 1'b1;
				end
				// The end line wins the vsync level when it equals the start line; both pulses are set.
				if (v_next == vend_q) begin
					vsync_next = 1'b1;
					raise      = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_count_q   <= 12'd0;
			v_count_q   <= 9'd0;
			field_q     <= 1'b0;
			hsync_q     <= 1'b0;
			vsync_q     <= 1'b0;
			geom_q      <= GEOM_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				h_count_q   <= h_next;
				v_count_q   <= v_next;
				field_q     <= field_next;
				hsync_q     <= hsync_next;
				vsync_q     <= vsync_next;
				geom_q      <= geom_next;
				res_valid_q <= 1'b1;
			end else if (timing_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.hsync_level        <= hsync_next;
			res_q.vsync_level        <= vsync_next;
			res_q.vblank_raise       <= raise;
			res_q.vblank_lower       <= lower;
			res_q.frame_ready        <= raise;
			res_q.field_odd          <= field_next;
			res_q.dot_divider        <= geom_next.dot_divider;
			res_q.display_width      <= geom_next.display_width;
			res_q.display_height     <= geom_next.display_height;
			res_q.display_interlaced <= geom_next.display_interlaced;
			res_q.h_position         <= h_next;
			res_q.v_position         <= v_next;
		end
	end

	assign timing_ch.valid = res_valid_q;
	assign timing_ch.data  = res_q;

endmodule

@@ rtl/vtg_checker.sv @@
// Port-level checker for the video timing generator and its bind statement.
// Depends on vtg_pkg and the video_timing_generator_unit top level.
module vtg_checker
	import vtg_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        tick_ready,
	input logic        timing_valid,
	input logic        timing_ready,
	input vtg_result_t timing_data
);

	// A result left waiting holds its value until it is taken.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		timing_valid && !timing_ready |=> timing_valid && $stable(timing_data))
		else $error("vtg: stalled result changed");

	// With one result register, a full and stalled output blocks new ticks.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		timing_valid && !timing_ready |-> !tick_ready)
		else $error("vtg: tick accepted over a stalled result");

	// Frame ready always travels with the vblank raise, which leaves vsync high.
	a_frame_ready: assert property (@(posedge clk) disable iff (!arst_n)
		timing_valid |-> (timing_data.frame_ready == timing_data.vblank_raise) &&
			(!timing_data.vblank_raise || timing_data.vsync_level))
		else $error("vtg: frame ready or vsync disagrees with vblank raise");

	// Vertical events only happen on the tick that wraps the line.
	a_line_events: assert property (@(posedge clk) disable iff (!arst_n)
		timing_valid && (timing_data.vblank_raise || timing_data.vblank_lower) |->
			timing_data.h_position == 12'd0 && !timing_data.hsync_level)
		else $error("vtg: vertical event away from the line wrap");

	// The horizontal counter never reaches the line total.
	a_h_range: assert property (@(posedge clk) disable iff (!arst_n)
		timing_valid |-> timing_data.h_position < H_TOTAL)
		else $error("vtg: horizontal position out of range");

endmodule

bind video_timing_generator_unit vtg_checker u_vtg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_ready   (tick_ch.ready),
	.timing_valid (timing_ch.valid),
	.timing_ready (timing_ch.ready),
	.timing_data  (timing_ch.data)
);
